// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the level meter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== rtl/core/spm_pkg.sv =====
// ----------------------------------------------------------------------------
// spm_pkg
// Shared constants, register indexes and lane control types of the meter.
// ----------------------------------------------------------------------------
package spm_pkg;

  // Sample and accumulator widths
  localparam int unsigned SAMPLE_BITS    = 16;
  localparam int unsigned PEAK_W         = SAMPLE_BITS;
  localparam int unsigned SQ_W           = 2 * SAMPLE_BITS - 1;
  localparam int unsigned SUM_W          = 43;
  localparam int unsigned MAX_FRAMES_DEF = 4096;

  // Configuration port
  localparam int unsigned REPORT_W   = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_EVERY = CFG_IDX_W'(1);

  // Block summary queue
  localparam int unsigned QUEUE_DEPTH = 2;

  // Square root unit
  localparam int unsigned ROOT_IN_W = SUM_W + (SUM_W % 2);
  localparam int unsigned SQ_STEPS  = ROOT_IN_W / 2;
  localparam int unsigned ROOT_W    = SQ_STEPS;
  localparam int unsigned RREM_W    = ROOT_W + 3;
  localparam int unsigned STEP_W    = $clog2(SUM_W);

  localparam logic [PEAK_W-1:0] FULL_SCALE = PEAK_W'(1) << (SAMPLE_BITS - 1);

  // Back end to lane control
  typedef struct packed {
    logic start;
    logic ack;
  } lane_ctl_t;

  // Lane to back end status
  typedef struct packed {
    logic idle;
    logic done;
  } lane_sts_t;

endpackage

// ===== rtl/core/stereo_peak_rms_meter.sv =====
// ----------------------------------------------------------------------------
// stereo_peak_rms_meter
// Stereo peak and RMS level meter over blocks of Q1.15 frames.
//
//   channel   direction  handshake                 payload
//   cfg       in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//   in        in         in_valid_i / in_stall_o   left/right_sample_i, last_frame_i
//   out       out        out_valid_o / out_stall_i peak/rms_left_o, peak/rms_right_o
//
// The front end takes one frame per cycle while in_stall_o is low; a frame is
// squared into the frame stage register, then added into the block sums.
// Each block result passes through the bit-serial divider and the
// two-bit-per-cycle square root; both channels run in parallel lanes.
// Up to QUEUE_DEPTH summaries wait in between.
// Reset clears the control state, counters and sums at once; no clearing pass.
// A held result stalls the lanes, then the queue, and finally the last frame
// of a measured block stalls the input.
// ----------------------------------------------------------------------------
module stereo_peak_rms_meter #(
  parameter int unsigned MAX_FRAMES = spm_pkg::MAX_FRAMES_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [spm_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [spm_pkg::CFG_DATA_W-1:0]         cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [spm_pkg::SAMPLE_BITS-1:0] left_sample_i,
  input  logic signed [spm_pkg::SAMPLE_BITS-1:0] right_sample_i,
  input  logic                                   last_frame_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [spm_pkg::PEAK_W-1:0]             peak_left_o,
  output logic [spm_pkg::PEAK_W-1:0]             rms_left_o,
  output logic [spm_pkg::PEAK_W-1:0]             peak_right_o,
  output logic [spm_pkg::PEAK_W-1:0]             rms_right_o
);

  localparam int unsigned CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int unsigned ENTRY_W = 2 * spm_pkg::PEAK_W + 2 * spm_pkg::SUM_W + CNT_W;

  logic               push_valid, push_ready, pop_valid, pop_ready;
  logic [ENTRY_W-1:0] push_data, pop_data;

  spm_front #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .last_frame_i   (last_frame_i),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_data_o    (push_data)
  );

  spm_queue #(
    .W     (ENTRY_W),
    .DEPTH (spm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  spm_back #(
    .CNT_W (CNT_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_data_i   (pop_data),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .peak_left_o  (peak_left_o),
    .rms_left_o   (rms_left_o),
    .peak_right_o (peak_right_o),
    .rms_right_o  (rms_right_o)
  );

endmodule

// ===== rtl/core/spm_front.sv =====
// ----------------------------------------------------------------------------
// spm_front
// Config registers, block phase, per-frame squaring and block accumulation.
// Pushes one block summary to the queue on the last frame of a measured block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spm_front #(
  parameter int unsigned MAX_FRAMES = spm_pkg::MAX_FRAMES_DEF,
  localparam int unsigned CNT_W     = $clog2(MAX_FRAMES + 1),
  localparam int unsigned ENTRY_W   = 2 * spm_pkg::PEAK_W + 2 * spm_pkg::SUM_W + CNT_W
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [spm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [spm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [spm_pkg::SAMPLE_BITS-1:0] left_sample_i,
  input  logic signed [spm_pkg::SAMPLE_BITS-1:0] right_sample_i,
  input  logic                              last_frame_i,
  output logic                              push_valid_o,
  input  logic                              push_ready_i,
  output logic [ENTRY_W-1:0]                push_data_o
);

  localparam int unsigned SB  = spm_pkg::SAMPLE_BITS;
  localparam int unsigned PW  = spm_pkg::PEAK_W;
  localparam int unsigned SW  = spm_pkg::SUM_W;
  localparam int unsigned RW  = spm_pkg::REPORT_W;

  // Two's complement magnitude; the most negative code maps to full scale
  function automatic logic [PW-1:0] mag_of(input logic [SB-1:0] s);
    mag_of = s[SB-1] ? PW'(~s + 1'b1) : PW'(s);
  endfunction

  logic          enable_q, enable_d;
  logic [RW-1:0] report_q, report_d;
  logic [RW-1:0] phase_q, phase_d;

  logic          st_valid_q, st_valid_d;
  logic          st_last_q;
  logic [PW-1:0] st_mag_l_q, st_mag_r_q;
  logic [spm_pkg::SQ_W-1:0] st_sq_l_q, st_sq_r_q;

  logic [SW-1:0]    sum_l_q, sum_l_d, sum_r_q, sum_r_d;
  logic [PW-1:0]    peak_l_q, peak_l_d, peak_r_q, peak_r_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [PW-1:0]    mag_l, mag_r;
  logic [2*PW-1:0]  prod_l, prod_r;
  logic             accept, measure, drain, wr_enable, wr_report;
  logic [RW:0]      phase_inc;
  logic [SW:0]      add_l, add_r;
  logic [SW-1:0]    sum_l_nx, sum_r_nx;
  logic [PW-1:0]    peak_l_nx, peak_r_nx;
  logic [CNT_W-1:0] cnt_nx;

  // Handshake and block classification
  assign drain        = st_valid_q && (!st_last_q || push_ready_i);
  assign in_stall_o   = st_valid_q && !drain;
  assign accept       = in_valid_i && !in_stall_o;
  assign measure      = enable_q && (phase_q == '0);
  assign push_valid_o = st_valid_q && st_last_q;

  assign wr_enable = cfg_we_i && (cfg_idx_i == spm_pkg::REG_ENABLE);
  assign wr_report = cfg_we_i && (cfg_idx_i == spm_pkg::REG_REPORT_EVERY) &&
                     (cfg_wdata_i[RW-1:0] != '0);

  // Squaring of the incoming frame
  always_comb begin
    mag_l  = mag_of(left_sample_i);
    mag_r  = mag_of(right_sample_i);
    prod_l = mag_l * mag_l;
    prod_r = mag_r * mag_r;
  end

  // Accumulator update with saturation
  always_comb begin
    add_l     = {1'b0, sum_l_q} + (SW+1)'(st_sq_l_q);
    add_r     = {1'b0, sum_r_q} + (SW+1)'(st_sq_r_q);
    sum_l_nx  = add_l[SW] ? '1 : add_l[SW-1:0];
    sum_r_nx  = add_r[SW] ? '1 : add_r[SW-1:0];
    peak_l_nx = (st_mag_l_q > peak_l_q) ? st_mag_l_q : peak_l_q;
    peak_r_nx = (st_mag_r_q > peak_r_q) ? st_mag_r_q : peak_r_q;
    cnt_nx    = (cnt_q < CNT_W'(MAX_FRAMES)) ? cnt_q + 1'b1 : cnt_q;
  end

  assign push_data_o = {peak_l_nx, peak_r_nx, sum_l_nx, sum_r_nx, cnt_nx};

  // Next state
  always_comb begin
    enable_d   = enable_q;
    report_d   = report_q;
    phase_d    = phase_q;
    st_valid_d = st_valid_q;
    sum_l_d    = sum_l_q;
    sum_r_d    = sum_r_q;
    peak_l_d   = peak_l_q;
    peak_r_d   = peak_r_q;
    cnt_d      = cnt_q;
    phase_inc  = {1'b0, phase_q} + (RW+1)'(1);

    if (wr_enable) begin
      enable_d = cfg_wdata_i[0];
    end

    if (wr_report) begin
      report_d = cfg_wdata_i[RW-1:0];
      phase_d  = '0;
    end else if (accept && enable_q && last_frame_i) begin
      phase_d = (phase_inc >= {1'b0, report_q}) ? '0 : phase_inc[RW-1:0];
    end

    if (accept && measure) begin
      st_valid_d = 1'b1;
    end else if (drain) begin
      st_valid_d = 1'b0;
    end

    if (wr_report || (drain && st_last_q)) begin
      sum_l_d  = '0;
      sum_r_d  = '0;
      peak_l_d = '0;
      peak_r_d = '0;
      cnt_d    = '0;
    end else if (drain) begin
      sum_l_d  = sum_l_nx;
      sum_r_d  = sum_r_nx;
      peak_l_d = peak_l_nx;
      peak_r_d = peak_r_nx;
      cnt_d    = cnt_nx;
    end
  end

  // Control and accumulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      report_q   <= RW'(1);
      phase_q    <= '0;
      st_valid_q <= 1'b0;
      sum_l_q    <= '0;
      sum_r_q    <= '0;
      peak_l_q   <= '0;
      peak_r_q   <= '0;
      cnt_q      <= '0;
    end else begin
      enable_q   <= enable_d;
      report_q   <= report_d;
      phase_q    <= phase_d;
      st_valid_q <= st_valid_d;
      sum_l_q    <= sum_l_d;
      sum_r_q    <= sum_r_d;
      peak_l_q   <= peak_l_d;
      peak_r_q   <= peak_r_d;
      cnt_q      <= cnt_d;
    end
  end

  // Frame stage payload
  always_ff @(posedge clk_i) begin
    if (accept && measure) begin
      st_last_q  <= last_frame_i;
      st_mag_l_q <= mag_l;
      st_mag_r_q <= mag_r;
      st_sq_l_q  <= prod_l[spm_pkg::SQ_W-1:0];
      st_sq_r_q  <= prod_r[spm_pkg::SQ_W-1:0];
    end
  end

  `ASSERT_NEVER(a_phase_range, clk_i, rst_ni, phase_q >= report_q,
                "block phase not below report_every")
  `ASSERT_AT(a_last_pushes, clk_i, rst_ni,
             accept && measure && last_frame_i |=> push_valid_o,
             "measured block end did not reach the queue")

endmodule

// ===== rtl/core/spm_queue.sv =====
// ----------------------------------------------------------------------------
// spm_queue
// Small FIFO of block summaries between the front and back ends.
// ----------------------------------------------------------------------------
module spm_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = spm_pkg::QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q < CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/spm_rms_unit.sv =====
// ----------------------------------------------------------------------------
// spm_rms_unit
// One channel lane: restoring divide of the square sum by the frame count,
// one quotient bit a cycle, then a digit-by-digit square root, two radicand
// bits a cycle, clamped to full scale.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spm_rms_unit #(
  parameter int unsigned CNT_W = $clog2(spm_pkg::MAX_FRAMES_DEF + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  spm_pkg::lane_ctl_t         ctl_i,
  output spm_pkg::lane_sts_t         sts_o,
  input  logic [spm_pkg::SUM_W-1:0]  sum_i,
  input  logic [CNT_W-1:0]           cnt_i,
  output logic [spm_pkg::PEAK_W-1:0] rms_o
);

  localparam int unsigned SW  = spm_pkg::SUM_W;
  localparam int unsigned RIW = spm_pkg::ROOT_IN_W;
  localparam int unsigned RTW = spm_pkg::ROOT_W;
  localparam int unsigned RRW = spm_pkg::RREM_W;
  localparam int unsigned STW = spm_pkg::STEP_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } state_e;

  state_e                    state_q;
  logic [STW-1:0]            step_q;
  logic [SW-1:0]             quo_q;
  logic [CNT_W-1:0]          div_q, drem_q;
  logic [RIW-1:0]            rad_q;
  logic [RTW-1:0]            root_q;
  logic [RRW-1:0]            rrem_q;
  logic [spm_pkg::PEAK_W-1:0] rms_q;

  logic [CNT_W:0]   drem_sh, ddiff;
  logic             dge, rge;
  logic [CNT_W-1:0] drem_nx;
  logic [SW-1:0]    quo_nx;
  logic [RRW-1:0]   rrem_sh, trial, rrem_nx;
  logic [RTW-1:0]   root_nx;
  logic [spm_pkg::PEAK_W-1:0] rms_nx;

  // Divider step
  always_comb begin
    drem_sh = {drem_q, quo_q[SW-1]};
    ddiff   = drem_sh - {1'b0, div_q};
    dge     = (drem_sh >= {1'b0, div_q});
    drem_nx = dge ? ddiff[CNT_W-1:0] : drem_sh[CNT_W-1:0];
    quo_nx  = {quo_q[SW-2:0], dge};
  end

  // Square root step and clamp
  always_comb begin
    rrem_sh = {rrem_q[RRW-3:0], rad_q[RIW-1 -: 2]};
    trial   = RRW'({root_q, 2'b01});
    rge     = (rrem_sh >= trial);
    rrem_nx = rge ? rrem_sh - trial : rrem_sh;
    root_nx = {root_q[RTW-2:0], rge};
    rms_nx  = (root_nx > RTW'(spm_pkg::FULL_SCALE)) ? spm_pkg::FULL_SCALE
                                                   : root_nx[spm_pkg::PEAK_W-1:0];
  end

  assign sts_o.idle = (state_q == ST_IDLE);
  assign sts_o.done = (state_q == ST_DONE);
  assign rms_o      = rms_q;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      quo_q   <= '0;
      div_q   <= '0;
      drem_q  <= '0;
      rad_q   <= '0;
      root_q  <= '0;
      rrem_q  <= '0;
      rms_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (ctl_i.start) begin
            quo_q   <= sum_i;
            div_q   <= cnt_i;
            drem_q  <= '0;
            step_q  <= STW'(SW - 1);
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          quo_q  <= quo_nx;
          drem_q <= drem_nx;
          if (step_q == '0) begin
            rad_q   <= RIW'(quo_nx);
            root_q  <= '0;
            rrem_q  <= '0;
            step_q  <= STW'(spm_pkg::SQ_STEPS - 1);
            state_q <= ST_SQRT;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        ST_SQRT: begin
          rad_q  <= rad_q << 2;
          root_q <= root_nx;
          rrem_q <= rrem_nx;
          if (step_q == '0) begin
            rms_q   <= rms_nx;
            state_q <= ST_DONE;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        ST_DONE: begin
          if (ctl_i.ack) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_AT(a_start_idle, clk_i, rst_ni, ctl_i.start |-> state_q == ST_IDLE,
             "lane started while busy")
  `ASSERT_AT(a_ack_done, clk_i, rst_ni, ctl_i.ack |-> state_q == ST_DONE,
             "lane acknowledged without a result")

endmodule

// ===== rtl/core/spm_back.sv =====
// ----------------------------------------------------------------------------
// spm_back
// Takes block summaries from the queue, runs both channel lanes in parallel
// and holds the finished result in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spm_back #(
  parameter int unsigned CNT_W    = $clog2(spm_pkg::MAX_FRAMES_DEF + 1),
  localparam int unsigned ENTRY_W = 2 * spm_pkg::PEAK_W + 2 * spm_pkg::SUM_W + CNT_W
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       pop_valid_i,
  output logic                       pop_ready_o,
  input  logic [ENTRY_W-1:0]         pop_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [spm_pkg::PEAK_W-1:0] peak_left_o,
  output logic [spm_pkg::PEAK_W-1:0] rms_left_o,
  output logic [spm_pkg::PEAK_W-1:0] peak_right_o,
  output logic [spm_pkg::PEAK_W-1:0] rms_right_o
);

  localparam int unsigned PW       = spm_pkg::PEAK_W;
  localparam int unsigned SW       = spm_pkg::SUM_W;
  localparam int unsigned SUMR_LSB = CNT_W;
  localparam int unsigned SUML_LSB = CNT_W + SW;
  localparam int unsigned PKR_LSB  = CNT_W + 2 * SW;
  localparam int unsigned PKL_LSB  = PKR_LSB + PW;

  spm_pkg::lane_ctl_t lane_ctl;
  spm_pkg::lane_sts_t sts_l, sts_r;
  logic [PW-1:0]      rms_l, rms_r;
  logic [PW-1:0]      pk_l_q, pk_r_q;
  logic               out_valid_q, out_valid_d;
  logic [PW-1:0]      peak_left_q, rms_left_q, peak_right_q, rms_right_q;
  logic               lanes_idle, both_done, out_free;

  // Lane control
  assign lanes_idle     = sts_l.idle && sts_r.idle;
  assign both_done      = sts_l.done && sts_r.done;
  assign out_free       = !out_valid_q || !out_stall_i;
  assign pop_ready_o    = lanes_idle;
  assign lane_ctl.start = pop_valid_i && lanes_idle;
  assign lane_ctl.ack   = both_done && out_free;

  spm_rms_unit #(
    .CNT_W (CNT_W)
  ) u_lane_l (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (lane_ctl),
    .sts_o  (sts_l),
    .sum_i  (pop_data_i[SUML_LSB +: SW]),
    .cnt_i  (pop_data_i[CNT_W-1:0]),
    .rms_o  (rms_l)
  );

  spm_rms_unit #(
    .CNT_W (CNT_W)
  ) u_lane_r (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (lane_ctl),
    .sts_o  (sts_r),
    .sum_i  (pop_data_i[SUMR_LSB +: SW]),
    .cnt_i  (pop_data_i[CNT_W-1:0]),
    .rms_o  (rms_r)
  );

  // Output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (lane_ctl.ack) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Peaks ride alongside the lanes; result register loads on completion
  always_ff @(posedge clk_i) begin
    if (lane_ctl.start) begin
      pk_l_q <= pop_data_i[PKL_LSB +: PW];
      pk_r_q <= pop_data_i[PKR_LSB +: PW];
    end
    if (lane_ctl.ack) begin
      peak_left_q  <= pk_l_q;
      rms_left_q   <= rms_l;
      peak_right_q <= pk_r_q;
      rms_right_q  <= rms_r;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign peak_left_o  = peak_left_q;
  assign rms_left_o   = rms_left_q;
  assign peak_right_o = peak_right_q;
  assign rms_right_o  = rms_right_q;

  `ASSERT_NEVER(a_lanes_lockstep, clk_i, rst_ni, sts_l.done != sts_r.done,
                "channel lanes out of step")
  `ASSERT_AT(a_ack_shows, clk_i, rst_ni, lane_ctl.ack |=> out_valid_o,
             "finished result not presented")

endmodule
